/* rtl/core/bsc_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the safety checker.
package bsc_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 16;
    localparam int SEQ_LIMIT     = 16;
    localparam int COUNT_BITS    = 16;
    localparam int PROC_LIMIT    = (MAX_PROCESSES < SEQ_LIMIT) ? MAX_PROCESSES : SEQ_LIMIT;
    localparam int PROC_BITS     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RES_BITS      = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int ADDR_BITS     = PROC_BITS + RES_BITS;
    localparam int TABLE_DEPTH   = MAX_PROCESSES * MAX_RESOURCES;
    localparam int CFG_BITS      = 5;
    localparam int PCNT_BITS     = $clog2(PROC_LIMIT + 1);
    localparam int RCNT_BITS     = $clog2(MAX_RESOURCES + 1);
    // work holds total minus up to PROC_LIMIT allocations, plus sign
    localparam int WORK_BITS     = COUNT_BITS + $clog2(PROC_LIMIT + 1) + 2;

    // item opcodes
    localparam logic [1:0] OP_SET_TOTAL = 2'd0;
    localparam logic [1:0] OP_LOAD_ROW  = 2'd1;
    localparam logic [1:0] OP_STAGE     = 2'd2;
    localparam logic [1:0] OP_CHECK     = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_SEQ    = 2'd1;
    localparam logic [1:0] STAT_UNSAFE = 2'd2;
    localparam logic [1:0] STAT_BAD    = 2'd3;

    // configuration register indexes
    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    // datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_SET_TOTAL,
        DP_LOAD_ROW,
        DP_STAGE_WR,
        DP_STAGE_START,
        DP_COPY_WR,
        DP_CHECK_INIT,
        DP_SUM_ACC,
        DP_SCAN_BEGIN,
        DP_SCAN_NEXT,
        DP_R_INC,
        DP_R_CLEAR,
        DP_ADD_ACC,
        DP_FINISH,
        DP_DROP_STAGE,
        DP_COMMIT_WR,
        DP_EMIT_BEGIN,
        DP_EMIT_NEXT
    } t_dp_cmd;

    // datapath status toward the controller
    typedef struct packed {
        logic [1:0]           op;
        logic                 bad_index;
        logic                 stage_hit;
        logic                 stale_stage;
        logic                 staged_valid;
        logic                 np_zero;
        logic                 nr_zero;
        logic                 last_r;
        logic                 r_all;
        logic                 p_end;
        logic                 p_last;
        logic                 count_full;
        logic                 finished_p;
        logic                 elem_fail;
        logic [PROC_BITS-1:0] seq_out;
    } t_dp_stat;

endpackage

/* rtl/core/bsc_dpath.sv */
// Datapath: tables, staged row, work vector, scan counters and safe sequence.
module bsc_dpath import bsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    input  logic [1:0]            i_op,
    input  logic [3:0]            i_proc_index,
    input  logic [3:0]            i_res_index,
    input  logic [15:0]           i_amount,
    input  logic [15:0]           i_allocated,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    // configuration
    logic [CFG_BITS-1:0]   r_pc, r_rc;
    logic [PCNT_BITS-1:0]  w_np;
    logic [RCNT_BITS-1:0]  w_nr;

    // latched item
    logic [1:0]            r_op;
    logic [3:0]            r_pi, r_ri;
    logic [COUNT_BITS-1:0] r_amt, r_alc;

    // tables
    logic [COUNT_BITS-1:0] r_max_mem   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] r_alloc_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] r_max_q, r_alloc_q;
    logic [COUNT_BITS-1:0] r_total [MAX_RESOURCES];
    logic [COUNT_BITS-1:0] r_srow  [MAX_RESOURCES];
    logic                  r_svalid;
    logic [PROC_BITS-1:0]  r_sproc;

    // check state
    logic [WORK_BITS-1:0]     r_work [MAX_RESOURCES];
    logic [PROC_BITS-1:0]     r_seq  [PROC_LIMIT];
    logic [MAX_PROCESSES-1:0] r_fin;
    logic [PCNT_BITS-1:0]     r_p, r_cnt;
    logic [RES_BITS-1:0]      r_r;

    logic [PROC_BITS-1:0]  w_p_idx;
    logic [ADDR_BITS-1:0]  w_rd_addr, w_wr_addr;
    logic                  w_alloc_we;
    logic [COUNT_BITS-1:0] w_alloc_wd;
    logic [COUNT_BITS-1:0] w_alloc_v;
    logic signed [COUNT_BITS:0]  w_need;
    logic signed [WORK_BITS-1:0] w_work_r;
    logic                  w_last_r;
    logic [PROC_BITS-1:0]  w_pi, w_ri_p;
    logic [RES_BITS-1:0]   w_ri;

    // counts in use, clamped
    always_comb begin
        w_np = (r_pc > CFG_BITS'(PROC_LIMIT)) ? PCNT_BITS'(PROC_LIMIT) : PCNT_BITS'(r_pc);
        w_nr = (r_rc > CFG_BITS'(MAX_RESOURCES)) ? RCNT_BITS'(MAX_RESOURCES)
                                                  : RCNT_BITS'(r_rc);
    end

    assign w_pi      = PROC_BITS'(r_pi);
    assign w_ri      = RES_BITS'(r_ri);
    assign w_ri_p    = w_pi;
    assign w_p_idx   = PROC_BITS'(r_p);
    assign w_rd_addr = {w_p_idx, r_r};

    // allocation seen by the check: staged row overrides its process
    assign w_alloc_v = (r_svalid && w_p_idx == r_sproc) ? r_srow[r_r] : r_alloc_q;
    assign w_need    = $signed({1'b0, r_max_q}) - $signed({1'b0, w_alloc_v});
    assign w_work_r  = $signed(r_work[r_r]);
    assign w_last_r  = (RCNT_BITS'(r_r) + RCNT_BITS'(1)) == w_nr;

    // table write port: row load or commit sweep
    always_comb begin
        w_alloc_we = 1'b0;
        w_alloc_wd = r_alc;
        w_wr_addr  = {w_ri_p, w_ri};
        if (i_cmd == DP_LOAD_ROW) begin
            w_alloc_we = 1'b1;
        end else if (i_cmd == DP_COMMIT_WR) begin
            w_alloc_we = 1'b1;
            w_alloc_wd = r_srow[r_r];
            w_wr_addr  = {r_sproc, r_r};
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd == DP_LOAD_ROW) begin
            r_max_mem[w_wr_addr] <= r_amt;
        end
        if (w_alloc_we) begin
            r_alloc_mem[w_wr_addr] <= w_alloc_wd;
        end
        r_max_q   <= r_max_mem[w_rd_addr];
        r_alloc_q <= r_alloc_mem[w_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_rc     <= '0;
            r_svalid <= 1'b0;
            r_sproc  <= '0;
            r_fin    <= '0;
            r_p      <= '0;
            r_r      <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_PROCESS_COUNT) r_pc <= i_cfg_data;
                else                                  r_rc <= i_cfg_data;
            end
            case (i_cmd)
                DP_STAGE_START: begin
                    r_svalid <= 1'b1;
                    r_sproc  <= w_pi;
                    r_p      <= PCNT_BITS'(w_pi);
                    r_r      <= '0;
                end
                DP_COPY_WR:    r_r <= r_r + RES_BITS'(1);
                DP_CHECK_INIT: begin
                    r_fin <= '0;
                    r_cnt <= '0;
                    r_p   <= '0;
                    r_r   <= '0;
                end
                DP_SUM_ACC, DP_ADD_ACC: begin
                    if (w_last_r) begin
                        r_r <= '0;
                        if (i_cmd == DP_SUM_ACC) r_p <= r_p + PCNT_BITS'(1);
                    end else begin
                        r_r <= r_r + RES_BITS'(1);
                    end
                end
                DP_SCAN_BEGIN, DP_EMIT_BEGIN: begin
                    r_p <= '0;
                    r_r <= '0;
                end
                DP_SCAN_NEXT: begin
                    r_p <= r_p + PCNT_BITS'(1);
                    r_r <= '0;
                end
                DP_R_INC:   r_r <= r_r + RES_BITS'(1);
                DP_R_CLEAR: r_r <= '0;
                DP_FINISH: begin
                    r_fin[w_p_idx] <= 1'b1;
                    r_cnt <= r_cnt + PCNT_BITS'(1);
                    r_p   <= '0;
                    r_r   <= '0;
                end
                DP_DROP_STAGE: r_svalid <= 1'b0;
                DP_COMMIT_WR: begin
                    r_r <= r_r + RES_BITS'(1);
                    if (&r_r) r_svalid <= 1'b0;
                end
                DP_EMIT_NEXT: r_p <= r_p + PCNT_BITS'(1);
                default: ;
            endcase
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LATCH: begin
                r_op  <= i_op;
                r_pi  <= i_proc_index;
                r_ri  <= i_res_index;
                r_amt <= COUNT_BITS'(i_amount);
                r_alc <= COUNT_BITS'(i_allocated);
            end
            DP_SET_TOTAL: r_total[w_ri] <= r_amt;
            DP_STAGE_WR:  r_srow[w_ri]  <= r_alc;
            DP_COPY_WR:   r_srow[r_r]   <= (r_r == w_ri) ? r_alc : r_alloc_q;
            DP_CHECK_INIT: begin
                for (int k = 0; k < MAX_RESOURCES; k++) begin
                    r_work[k] <= WORK_BITS'(r_total[k]);
                end
            end
            DP_SUM_ACC: r_work[r_r] <= r_work[r_r] - WORK_BITS'(w_alloc_v);
            DP_ADD_ACC: r_work[r_r] <= r_work[r_r] + WORK_BITS'(w_alloc_v);
            DP_FINISH:  r_seq[r_cnt[PROC_BITS-1:0]] <= w_p_idx;
            default: ;
        endcase
    end

    // status
    always_comb begin
        o_stat.op           = r_op;
        o_stat.bad_index    = (RCNT_BITS'(r_ri) >= w_nr) ||
                              ((r_op != OP_SET_TOTAL) && (PCNT_BITS'(r_pi) >= w_np));
        o_stat.stage_hit    = r_svalid && (r_sproc == w_pi);
        o_stat.stale_stage  = r_svalid && (PCNT_BITS'(r_sproc) >= w_np);
        o_stat.staged_valid = r_svalid;
        o_stat.np_zero      = (w_np == '0);
        o_stat.nr_zero      = (w_nr == '0);
        o_stat.last_r       = w_last_r;
        o_stat.r_all        = &r_r;
        o_stat.p_end        = (r_p == w_np);
        o_stat.p_last       = (r_p + PCNT_BITS'(1)) == w_np;
        o_stat.count_full   = (r_cnt == w_np);
        o_stat.finished_p   = r_fin[w_p_idx];
        o_stat.elem_fail    = (w_need < 0) || (WORK_BITS'(w_need) > w_work_r) &&
                              ($signed(WORK_BITS'(w_need)) > w_work_r);
        o_stat.seq_out      = r_seq[w_p_idx];
    end

endmodule

/* rtl/core/bsc_ctrl.sv */
// Controller: sequences loads, staging copy, check scan, commit and result output.
module bsc_ctrl import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_seq_process,
    output logic        o_last,
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_COPY_RD, S_COPY_WR, S_DONE, S_SUM_RD, S_SUM_ACC,
        S_SCAN_BEGIN, S_SCAN_P, S_SCAN_RD, S_SCAN_USE, S_ADD_RD, S_ADD_USE,
        S_FINISH, S_COMMIT, S_RESULT
    } t_state;

    t_state     r_state, n_state;
    logic       r_ov, n_ov;
    logic [1:0] r_status, n_status;
    logic [3:0] r_seq, n_seq;
    logic       r_last, n_last;
    logic       w_free;

    assign w_free        = !r_ov || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_status      = r_status;
    assign o_seq_process = r_seq;
    assign o_last        = r_last;

    // next state, command and result register
    always_comb begin
        n_state  = r_state;
        n_ov     = r_ov && !i_out_ready;
        n_status = r_status;
        n_seq    = r_seq;
        n_last   = r_last;
        o_cmd    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (w_free) begin
                    if (i_stat.op == OP_CHECK) begin
                        if (i_stat.stale_stage) begin
                            o_cmd    = DP_DROP_STAGE;
                            n_ov     = 1'b1;
                            n_status = STAT_BAD;
                            n_seq    = '0;
                            n_last   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_cmd   = DP_CHECK_INIT;
                            n_state = (i_stat.np_zero || i_stat.nr_zero) ? S_SCAN_P
                                                                        : S_SUM_RD;
                        end
                    end else if (i_stat.bad_index) begin
                        n_ov     = 1'b1;
                        n_status = STAT_BAD;
                        n_seq    = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (i_stat.op == OP_STAGE && !i_stat.stage_hit) begin
                        o_cmd   = DP_STAGE_START;
                        n_state = S_COPY_RD;
                    end else begin
                        case (i_stat.op)
                            OP_SET_TOTAL: o_cmd = DP_SET_TOTAL;
                            OP_LOAD_ROW:  o_cmd = DP_LOAD_ROW;
                            default:      o_cmd = DP_STAGE_WR;
                        endcase
                        n_ov     = 1'b1;
                        n_status = STAT_DONE;
                        n_seq    = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            // fresh staged row copied from the table, one element a pass
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: begin
                o_cmd   = DP_COPY_WR;
                n_state = i_stat.r_all ? S_DONE : S_COPY_RD;
            end
            S_DONE: begin
                if (w_free) begin
                    n_ov     = 1'b1;
                    n_status = STAT_DONE;
                    n_seq    = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            // available = total minus column sums
            S_SUM_RD: n_state = S_SUM_ACC;
            S_SUM_ACC: begin
                o_cmd   = DP_SUM_ACC;
                n_state = (i_stat.last_r && i_stat.p_last) ? S_SCAN_BEGIN : S_SUM_RD;
            end
            S_SCAN_BEGIN: begin
                o_cmd   = DP_SCAN_BEGIN;
                n_state = S_SCAN_P;
            end
            // pick lowest unfinished process that fits
            S_SCAN_P: begin
                if (i_stat.count_full) begin
                    n_state = S_COMMIT;
                end else if (i_stat.p_end) begin
                    if (w_free) begin
                        o_cmd    = DP_DROP_STAGE;
                        n_ov     = 1'b1;
                        n_status = STAT_UNSAFE;
                        n_seq    = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.finished_p) begin
                    o_cmd = DP_SCAN_NEXT;
                end else if (i_stat.nr_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_USE;
            S_SCAN_USE: begin
                if (i_stat.elem_fail) begin
                    o_cmd   = DP_SCAN_NEXT;
                    n_state = S_SCAN_P;
                end else if (i_stat.last_r) begin
                    o_cmd   = DP_R_CLEAR;
                    n_state = S_ADD_RD;
                end else begin
                    o_cmd   = DP_R_INC;
                    n_state = S_SCAN_RD;
                end
            end
            // release the chosen process's allocation into work
            S_ADD_RD: n_state = S_ADD_USE;
            S_ADD_USE: begin
                o_cmd   = DP_ADD_ACC;
                n_state = i_stat.last_r ? S_FINISH : S_ADD_RD;
            end
            S_FINISH: begin
                o_cmd   = DP_FINISH;
                n_state = S_SCAN_P;
            end
            // write the staged row back, then report
            S_COMMIT: begin
                if (i_stat.staged_valid) begin
                    o_cmd = DP_COMMIT_WR;
                end else begin
                    o_cmd   = DP_EMIT_BEGIN;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_free) begin
                    n_ov = 1'b1;
                    if (i_stat.np_zero) begin
                        n_status = STAT_DONE;
                        n_seq    = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        o_cmd    = DP_EMIT_NEXT;
                        n_status = STAT_SEQ;
                        n_seq    = 4'(i_stat.seq_out);
                        n_last   = i_stat.p_last;
                        if (i_stat.p_last) n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_status <= STAT_DONE;
            r_seq    <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ov     <= n_ov;
            r_status <= n_status;
            r_seq    <= n_seq;
            r_last   <= n_last;
        end
    end

endmodule

/* rtl/core/bankers_safety_check.sv */
// Top level of the banker's algorithm safety checker.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, op, indexes, amounts     | item in
//  out     | o_out_valid/i_out_ready, status, seq_process    | result out
//  cfg     | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data| reg write
//
// One item at a time: a load or in-row stage posts its result from the decode
// state, and the next item is taken once it is posted. A stage that starts a new
// row first copies the process's 16 allocation entries from the table. A check
// reads the table through the single read port, for available and then for the
// scan, writes the staged row's 16 entries back and posts one result per process.
// Reset is synchronous; tables need no clearing.
// A stalled output holds the controller before it loads the next result.
module bankers_safety_check import bsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_op,
    input  logic [3:0]          i_proc_index,
    input  logic [3:0]          i_res_index,
    input  logic [15:0]         i_amount,
    input  logic [15:0]         i_allocated,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [3:0]          o_seq_process,
    output logic                o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    bsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_seq_process (o_seq_process),
        .o_last        (o_last),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    bsc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_proc_index (i_proc_index),
        .i_res_index  (i_res_index),
        .i_amount     (i_amount),
        .i_allocated  (i_allocated),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

endmodule

/* tb/bsc_checker.sv */
// Checker for the safety checker: tracks config writes, predicts results, compares them.
`timescale 1ns / 1ps
module bsc_checker import bsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_op,
    input  logic [3:0]          i_proc_index,
    input  logic [3:0]          i_res_index,
    input  logic [15:0]         i_amount,
    input  logic [15:0]         i_allocated,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          i_status,
    input  logic [3:0]          i_seq_process,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_safe_checks,
    output int                  o_unsafe_checks
);

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] proc;
        logic       last;
    } t_result;

    // shadow copy of the block's tables and registers
    bit [15:0] max_tbl   [16][16];
    bit [15:0] alloc_tbl [16][16];
    bit [15:0] total_tbl [16];
    bit [15:0] stage_row [16];
    bit        stage_vld;
    bit [3:0]  stage_proc;
    bit [4:0]  proc_cfg;
    bit [4:0]  res_cfg;

    t_result expected_results[$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_safe_checks   = 0;
        o_unsafe_checks = 0;
    end

    function automatic int procs_used();
        return (proc_cfg > 16) ? 16 : int'(proc_cfg);
    endfunction

    function automatic int res_used();
        return (res_cfg > 16) ? 16 : int'(res_cfg);
    endfunction

    // the staged row stands in for its process during a check
    function automatic longint alloc_seen(int p, int r);
        if (stage_vld && p == stage_proc) return stage_row[r];
        return alloc_tbl[p][r];
    endfunction

    task automatic push_result(logic [1:0] st, logic [3:0] p, logic lst);
        t_result e;
        e.status = st;
        e.proc   = p;
        e.last   = lst;
        expected_results.push_back(e);
    endtask

    // safety scan: lowest-indexed runnable process first
    task automatic run_safety_scan();
        int      np;
        int      nr;
        int      count;
        bit      found;
        bit      fits;
        bit [15:0] done_mask;
        longint  work [16];
        longint  sum;
        longint  need;
        int      order [16];
        np = procs_used();
        nr = res_used();
        count = 0;
        done_mask = '0;
        if (stage_vld && stage_proc >= np) begin
            stage_vld = 0;
            push_result(STAT_BAD, 4'd0, 1'b1);
            return;
        end
        for (int r = 0; r < nr; r++) begin
            sum = 0;
            for (int p = 0; p < np; p++) sum += alloc_seen(p, r);
            work[r] = longint'(total_tbl[r]) - sum;
        end
        while (count < np) begin
            found = 0;
            for (int p = 0; p < np && !found; p++) begin
                if (!done_mask[p]) begin
                    fits = 1;
                    for (int r = 0; r < nr && fits; r++) begin
                        need = longint'(max_tbl[p][r]) - alloc_seen(p, r);
                        if (need < 0 || need > work[r]) fits = 0;
                    end
                    if (fits) begin
                        for (int r = 0; r < nr; r++) work[r] += alloc_seen(p, r);
                        done_mask[p] = 1;
                        order[count] = p;
                        count++;
                        found = 1;
                    end
                end
            end
            if (!found) begin
                stage_vld = 0;
                o_unsafe_checks++;
                push_result(STAT_UNSAFE, 4'd0, 1'b1);
                return;
            end
        end
        if (stage_vld) begin
            for (int r = 0; r < 16; r++) alloc_tbl[stage_proc][r] = stage_row[r];
            stage_vld = 0;
        end
        o_safe_checks++;
        if (np == 0) begin
            push_result(STAT_DONE, 4'd0, 1'b1);
        end else begin
            for (int k = 0; k < np; k++) push_result(STAT_SEQ, order[k][3:0], k == np - 1);
        end
    endtask

    task automatic predict_item(logic [1:0] op, logic [3:0] pi, logic [3:0] ri,
                                logic [15:0] amt, logic [15:0] alc);
        if (op == OP_CHECK) begin
            run_safety_scan();
        end else if (ri >= res_used() || (op != OP_SET_TOTAL && pi >= procs_used())) begin
            push_result(STAT_BAD, 4'd0, 1'b1);
        end else begin
            case (op)
                OP_SET_TOTAL: total_tbl[ri] = amt;
                OP_LOAD_ROW: begin
                    max_tbl[pi][ri]   = amt;
                    alloc_tbl[pi][ri] = alc;
                end
                default: begin
                    if (!stage_vld || stage_proc != pi) begin
                        for (int r = 0; r < 16; r++) stage_row[r] = alloc_tbl[pi][r];
                        stage_proc = pi;
                        stage_vld  = 1;
                    end
                    stage_row[ri] = alc;
                end
            endcase
            push_result(STAT_DONE, 4'd0, 1'b1);
        end
    endtask

    // sample at the falling edge: values here are what the next rising edge takes
    always @(negedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_PROCESS_COUNT) proc_cfg = i_cfg_data;
                else res_cfg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_op, i_proc_index, i_res_index, i_amount, i_allocated);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: status %0d seq_process %0d",
                           i_status, i_seq_process);
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (i_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, i_status);
                        o_fail_count++;
                    end
                    if (i_seq_process !== e.proc) begin
                        $error("seq_process: expected %0d, got %0d", e.proc, i_seq_process);
                        o_fail_count++;
                    end
                    if (i_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, i_last);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for the safety checker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import bsc_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_op;
    logic [3:0]          i_proc_index;
    logic [3:0]          i_res_index;
    logic [15:0]         i_amount;
    logic [15:0]         i_allocated;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_status;
    logic [3:0]          o_seq_process;
    logic                o_last;

    int fail_count;
    int pending;
    int safe_checks;
    int unsafe_checks;
    int items_sent;
    bit calm;
    int use_np;
    int use_nr;
    // which table entries hold defined data
    bit total_set [16];
    bit row_set   [16][16];

    bankers_safety_check u_dut (.*);

    bsc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_proc_index   (i_proc_index),
        .i_res_index    (i_res_index),
        .i_amount       (i_amount),
        .i_allocated    (i_allocated),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_seq_process  (o_seq_process),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_safe_checks  (safe_checks),
        .o_unsafe_checks(unsafe_checks)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 26);
    end

    initial begin
        #20ms;
        $display("bankers_safety_check test failed");
        $finish;
    end

    task automatic send_item(logic [1:0] op, logic [3:0] pi, logic [3:0] ri,
                             logic [15:0] amt, logic [15:0] alc);
        if (!calm) begin
            while ($urandom_range(99) < 26) begin
                i_in_valid <= 0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1;
        i_op         <= op;
        i_proc_index <= pi;
        i_res_index  <= ri;
        i_amount     <= amt;
        i_allocated  <= alc;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (op == OP_SET_TOTAL && ri < use_nr) total_set[ri] = 1;
        if (op == OP_LOAD_ROW && ri < use_nr && pi < use_np) row_set[pi][ri] = 1;
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
        if (idx == REG_PROCESS_COUNT) use_np = (val > 16) ? 16 : val;
        else use_nr = (val > 16) ? 16 : val;
    endtask

    // empty sizes read no table, so this check safely drops any staged row
    task automatic set_sizes(int np, int nr);
        drain();
        write_reg(REG_PROCESS_COUNT, '0);
        write_reg(REG_RESOURCE_COUNT, '0);
        send_item(OP_CHECK, '0, '0, '0, '0);
        drain();
        write_reg(REG_PROCESS_COUNT, np[CFG_BITS-1:0]);
        write_reg(REG_RESOURCE_COUNT, nr[CFG_BITS-1:0]);
    endtask

    function automatic logic [15:0] rand_count(int hi);
        if ($urandom_range(99) < 8) return 16'($urandom_range(65535));
        return 16'($urandom_range(hi));
    endfunction

    // first entry a check would read that holds no data yet
    function automatic bit find_gap(output logic [1:0] op, output logic [3:0] pi,
                                    output logic [3:0] ri);
        op = OP_LOAD_ROW;
        pi = '0;
        ri = '0;
        for (int r = 0; r < use_nr; r++) begin
            if (!total_set[r]) begin
                op = OP_SET_TOTAL;
                ri = r[3:0];
                return 1;
            end
        end
        for (int p = 0; p < use_np; p++) begin
            for (int r = 0; r < use_nr; r++) begin
                if (!row_set[p][r]) begin
                    pi = p[3:0];
                    ri = r[3:0];
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic bit row_ready(int p);
        for (int r = 0; r < use_nr; r++) if (!row_set[p][r]) return 0;
        return 1;
    endfunction

    task automatic random_item();
        logic [1:0]  op;
        logic [3:0]  pi;
        logic [3:0]  ri;
        logic [1:0]  gop;
        logic [3:0]  gpi;
        logic [3:0]  gri;
        logic [15:0] mx;
        bit          gap;
        int          pick;
        gap  = find_gap(gop, gpi, gri);
        pick = $urandom_range(99);
        pi   = 4'($urandom_range(use_np > 0 ? use_np - 1 : 0));
        ri   = 4'($urandom_range(use_nr > 0 ? use_nr - 1 : 0));
        mx   = rand_count(10);
        if (pick < 10) begin
            // out-of-range index
            op = 2'($urandom_range(2));
            pi = 4'($urandom_range(15));
            ri = (use_nr < 16) ? 4'($urandom_range(15, use_nr)) : 4'($urandom_range(15));
            if (op != OP_SET_TOTAL && use_np < 16) pi = 4'($urandom_range(15, use_np));
            if (op == OP_STAGE && ri < use_nr && pi < use_np && !row_ready(pi))
                op = OP_LOAD_ROW;
            send_item(op, pi, ri, mx, 16'($urandom_range(65535)));
        end else if (gap && pick < 60) begin
            send_item(gop, gpi, gri, gop == OP_SET_TOTAL ? 16'($urandom_range(10, 40)) : mx,
                      16'($urandom_range(mx > 4 ? 4 : mx)));
        end else begin
            pick = $urandom_range(99);
            if (pick < 15) op = OP_SET_TOTAL;
            else if (pick < 35) op = OP_LOAD_ROW;
            else if (pick < 65) op = OP_STAGE;
            else op = OP_CHECK;
            if (op == OP_STAGE && use_np > 0 && use_nr > 0 && !row_ready(pi)) op = OP_LOAD_ROW;
            if (op == OP_CHECK && gap) begin
                op = gop;
                pi = gpi;
                ri = gri;
            end
            case (op)
                OP_SET_TOTAL: send_item(op, pi, ri, 16'($urandom_range(5, 40)), '0);
                OP_LOAD_ROW:
                    send_item(op, pi, ri, mx, $urandom_range(99) < 10 ?
                              rand_count(12) : 16'($urandom_range(mx > 6 ? 6 : mx)));
                OP_STAGE: send_item(op, pi, ri, '0, rand_count(8));
                default: send_item(op, '0, '0, '0, '0);
            endcase
        end
    endtask

    task automatic random_phase(int np, int nr, int count);
        set_sizes(np, nr);
        repeat (count) random_item();
    endtask

    initial begin
        i_rst_n      = 0;
        i_cfg_valid  = 0;
        i_cfg_index  = REG_PROCESS_COUNT;
        i_cfg_data   = '0;
        i_in_valid   = 0;
        i_op         = OP_SET_TOTAL;
        i_proc_index = '0;
        i_res_index  = '0;
        i_amount     = '0;
        i_allocated  = '0;
        i_out_ready  = 0;
        calm         = 0;
        items_sent   = 0;
        use_np       = 0;
        use_nr       = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, negative need, unsafe, commit, restage, bad index, stale stage
        write_reg(REG_PROCESS_COUNT, 5'd2);
        write_reg(REG_RESOURCE_COUNT, 5'd2);
        send_item(OP_SET_TOTAL, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_SET_TOTAL, 4'd0, 4'd1, 16'h0000, 16'h0000);
        send_item(OP_LOAD_ROW, 4'd0, 4'd0, 16'hFFFF, 16'h0000);
        send_item(OP_LOAD_ROW, 4'd0, 4'd1, 16'h0000, 16'hFFFF);
        send_item(OP_LOAD_ROW, 4'd1, 4'd0, 16'd5, 16'd5);
        send_item(OP_LOAD_ROW, 4'd1, 4'd1, 16'd0, 16'd0);
        send_item(OP_CHECK, 4'd0, 4'd0, 16'd0, 16'd0);
        send_item(OP_LOAD_ROW, 4'd0, 4'd1, 16'd0, 16'd0);
        send_item(OP_CHECK, 4'd0, 4'd0, 16'd0, 16'd0);
        send_item(OP_STAGE, 4'd1, 4'd0, 16'd0, 16'd0);
        send_item(OP_CHECK, 4'd0, 4'd0, 16'd0, 16'd0);
        send_item(OP_STAGE, 4'd0, 4'd1, 16'd0, 16'd1);
        send_item(OP_STAGE, 4'd0, 4'd0, 16'd0, 16'd3);
        send_item(OP_STAGE, 4'd1, 4'd0, 16'd0, 16'd2);
        send_item(OP_CHECK, 4'd0, 4'd0, 16'd0, 16'd0);
        send_item(OP_SET_TOTAL, 4'd0, 4'd2, 16'd1, 16'd0);
        send_item(OP_LOAD_ROW, 4'd2, 4'd0, 16'd1, 16'd1);
        send_item(OP_STAGE, 4'd3, 4'd15, 16'd0, 16'hFFFF);
        send_item(OP_LOAD_ROW, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
        send_item(OP_STAGE, 4'd1, 4'd1, 16'd0, 16'd7);
        drain();
        write_reg(REG_PROCESS_COUNT, 5'd1);
        send_item(OP_CHECK, 4'd0, 4'd0, 16'd0, 16'd0);

        // random phases over a spread of table sizes
        random_phase(3, 2, 25);
        random_phase(5, 3, 30);
        calm = 1;
        random_phase(4, 4, 30);
        calm = 0;
        random_phase(1, 1, 12);
        random_phase(16, 1, 20);
        random_phase(1, 16, 20);
        random_phase(2, 0, 10);
        random_phase(0, 5, 10);
        random_phase(31, 31, 15);
        random_phase(6, 2, 25);

        drain();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d items over ten table sizes and the directed cases;", items_sent);
        $display("%0d checks came out safe and %0d unsafe.", safe_checks, unsafe_checks);
        if (fail_count == 0) begin
            $display("bankers_safety_check test passed");
        end else begin
            $display("bankers_safety_check test failed");
        end
        $finish;
    end

endmodule
